>>> hw/rtl/rbsc_pkg.sv
// shared types, codes and helpers of the rigid body step and contact core
`default_nettype none
package rbsc_pkg;

  // width of the shared multiplier operands and of its product
  localparam int OPW  = 34;
  localparam int WW   = 68;
  localparam int AXES = 3;

  // reciprocal constants for division by 60 and by 100, product shifted by DIV_SHIFT
  localparam int DIV_SHIFT = 38;
  localparam logic signed [OPW-1:0] M60  = 34'sd4581298449;
  localparam logic signed [OPW-1:0] M100 = 34'sd2748779069;

  typedef logic signed [WW-1:0] wide_t;

  // input item kinds
  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_CONTACT = 3'd1,
    MODE_CCD     = 3'd2,
    MODE_LDPOS   = 3'd3,
    MODE_LDVEL   = 3'd4
  } mode_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_FREEZE  = 3'd0,
    CFG_GRAVITY = 3'd1,
    CFG_KINEM   = 3'd2,
    CFG_REST    = 3'd3,
    CFG_RADIUS  = 3'd4,
    CFG_OFF_X   = 3'd5,
    CFG_OFF_Y   = 3'd6,
    CFG_OFF_Z   = 3'd7
  } cfg_idx_t;

  // datapath micro operations
  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_GRAV, OP_T_MUL, OP_T_USE, OP_P_MUL, OP_P_USE,
    OP_R_MUL, OP_R_USE, OP_C_MUL, OP_C_USE, OP_N_MUL, OP_N_USE,
    OP_E_MUL, OP_E_USE, OP_D_MUL, OP_D_USE, OP_LDPOS, OP_LDVEL, OP_FIN
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_GRAV, S_TMUL, S_TUSE, S_PMUL, S_PUSE, S_RMUL, S_RUSE,
    S_CMUL, S_CUSE, S_NMUL, S_NUSE, S_VNFIX, S_EMUL, S_EUSE, S_DMUL,
    S_DUSE, S_LDPOS, S_LDVEL, S_FIN
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic kinematic;
    logic vn_neg;
    logic out_free;
  } dp_stat_t;

  localparam logic [1:0] AXIS_LAST = 2'd2;

  // saturate a wide signed value to 32 bits signed
  function automatic logic signed [31:0] sat32(input wide_t v);
    logic signed [31:0] r;
    if (v > wide_t'(64'sh7FFF_FFFF)) r = 32'sh7FFF_FFFF;
    else if (v < -wide_t'(64'sh8000_0000)) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rigid_body_step_and_contact_core.sv
// top level of the rigid body step and contact core
// Keeps one body's position and velocity in signed fixed point and updates them
// per request on the s_ channel: tick, contact, ccd contact, load position or
// load velocity. Every request yields one result on the m_ channel: the
// position and velocity after it.
// The config port (cfg_we, cfg_index, cfg_data) writes one register per cycle
// and should only be used while no request is in flight.
// A kinematic or unused request goes straight to its result; loads also apply
// to a kinematic body. A contact or ccd contact changes the velocity only when
// the normal velocity approaches the surface. All products go through a single
// shared multiplier, and one request is worked at a time.
// s_tready is high only while the sequencer is idle. The result sits in an
// output register: a stalled m_ channel holds it while the next request is
// already taken and worked; that request then waits for the slot.
// Synchronous reset clears position, velocity and config to their defaults
// (gravity on) and empties the result register.
`default_nettype none
module rigid_body_step_and_contact_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // mode, vec_x, vec_y, vec_z, penetration, contact_x, contact_y, contact_z, pad
  input  wire logic [231:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  output logic [191:0]      m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import rbsc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;
  logic     in_fire;

  assign in_fire = s_tvalid && s_tready;

  // sequencer
  rbsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_mode  (s_tdata[2:0]),
    .st       (st),
    .cmd      (cmd),
    .in_ready (s_tready)
  );

  // datapath
  rbsc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .out_data  (m_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

endmodule
`default_nettype wire

>>> hw/rtl/rbsc_ctrl.sv
// sequencer that steps the datapath through the micro operations of one item
`default_nettype none
module rbsc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_fire,
  input  wire logic [2:0]         in_mode,
  input  wire rbsc_pkg::dp_stat_t st,
  output rbsc_pkg::dp_cmd_t       cmd,
  output logic                    in_ready
);
  import rbsc_pkg::*;

  ctrl_state_t state, state_next;
  logic [1:0]  axis, axis_next;
  logic        last;

  assign last = (axis == AXIS_LAST);

  // state and axis registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 2'd0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    axis_next  = axis;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (mode_t'(in_mode))
            MODE_TICK:    state_next = st.kinematic ? S_FIN : S_GRAV;
            MODE_CONTACT: state_next = st.kinematic ? S_FIN : S_PMUL;
            MODE_CCD:     state_next = st.kinematic ? S_FIN : S_RMUL;
            MODE_LDPOS:   state_next = S_LDPOS;
            MODE_LDVEL:   state_next = S_LDVEL;
            default:      state_next = S_FIN;
          endcase
        end
      end
      S_GRAV: state_next = S_TMUL;
      S_TMUL: state_next = S_TUSE;
      S_TUSE: begin
        state_next = last ? S_FIN : S_TMUL;
        axis_next  = last ? 2'd0 : axis + 2'd1;
      end
      S_PMUL: state_next = S_PUSE;
      S_PUSE: begin
        state_next = last ? S_NMUL : S_PMUL;
        axis_next  = last ? 2'd0 : axis + 2'd1;
      end
      S_RMUL: state_next = S_RUSE;
      S_RUSE: state_next = S_CMUL;
      S_CMUL: state_next = S_CUSE;
      S_CUSE: begin
        state_next = last ? S_NMUL : S_CMUL;
        axis_next  = last ? 2'd0 : axis + 2'd1;
      end
      S_NMUL: state_next = S_NUSE;
      S_NUSE: begin
        state_next = last ? S_VNFIX : S_NMUL;
        axis_next  = last ? 2'd0 : axis + 2'd1;
      end
      S_VNFIX: state_next = st.vn_neg ? S_EMUL : S_FIN;
      S_EMUL:  state_next = S_EUSE;
      S_EUSE:  state_next = S_DMUL;
      S_DMUL:  state_next = S_DUSE;
      S_DUSE: begin
        state_next = last ? S_FIN : S_DMUL;
        axis_next  = last ? 2'd0 : axis + 2'd1;
      end
      S_LDPOS: state_next = S_FIN;
      S_LDVEL: state_next = S_FIN;
      S_FIN:   state_next = st.out_free ? S_IDLE : S_FIN;
      default: state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd.axis = axis;
    cmd.op   = OP_NONE;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = in_fire ? OP_LATCH : OP_NONE;
      end
      S_GRAV:  cmd.op = OP_GRAV;
      S_TMUL:  cmd.op = OP_T_MUL;
      S_TUSE:  cmd.op = OP_T_USE;
      S_PMUL:  cmd.op = OP_P_MUL;
      S_PUSE:  cmd.op = OP_P_USE;
      S_RMUL:  cmd.op = OP_R_MUL;
      S_RUSE:  cmd.op = OP_R_USE;
      S_CMUL:  cmd.op = OP_C_MUL;
      S_CUSE:  cmd.op = OP_C_USE;
      S_NMUL:  cmd.op = OP_N_MUL;
      S_NUSE:  cmd.op = OP_N_USE;
      S_VNFIX: cmd.op = OP_NONE;
      S_EMUL:  cmd.op = OP_E_MUL;
      S_EUSE:  cmd.op = OP_E_USE;
      S_DMUL:  cmd.op = OP_D_MUL;
      S_DUSE:  cmd.op = OP_D_USE;
      S_LDPOS: cmd.op = OP_LDPOS;
      S_LDVEL: cmd.op = OP_LDVEL;
      S_FIN:   cmd.op = st.out_free ? OP_FIN : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/rbsc_dp.sv
// datapath: body state, config registers, shared multiplier and result register
`default_nettype none
module rbsc_dp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rbsc_pkg::dp_cmd_t cmd,
  output rbsc_pkg::dp_stat_t     st,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic [231:0]      in_data,
  output logic [191:0]           out_data,
  output logic                   out_valid,
  input  wire logic              out_ready
);
  import rbsc_pkg::*;

  localparam longint GRAV     = ((longint'(98) << FRAC_BITS) + 300) / 600;
  localparam longint REST_MIN = ((longint'(1) << FRAC_BITS) * 2 + 5) / 10;
  localparam longint ONE_M1   = (longint'(1) << FRAC_BITS) - 1;

  // config registers
  logic [2:0]         freeze;
  logic               grav_en;
  logic               kinem;
  logic [17:0]        rest;
  logic [30:0]        radius;
  logic signed [31:0] off [AXES];

  // body state and work registers
  logic signed [31:0]    pos [AXES];
  logic signed [31:0]    vel [AXES];
  logic signed [31:0]    vec [AXES];
  logic signed [31:0]    cpt [AXES];
  logic signed [31:0]    pen;
  logic signed [OPW-1:0] reach;
  logic signed [31:0]    delta;
  wide_t                 acc;
  wide_t                 prod;
  logic signed [31:0]    out_pos [AXES];
  logic signed [31:0]    out_vel [AXES];

  logic signed [31:0]    pa, va, na, vn;
  logic signed [OPW-1:0] ma, mb, vext;
  logic [OPW-1:0]        x60, x100, r60, r100;
  logic [29:0]           qe;
  logic [29:0]           q60, q100;
  wide_t                 fm, step;
  logic signed [31:0]    nvn;

  assign pa = pos[cmd.axis];
  assign va = vel[cmd.axis];
  assign na = vec[cmd.axis];
  assign vn = sat32(acc);

  // dividend forms for the rounded division by 60 and by 100
  assign vext = OPW'(va);
  assign x60  = OPW'((vext < 0) ? -vext : vext) + OPW'(30);
  assign x100 = OPW'(radius) + OPW'(50);

  // operand selection of the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_T_MUL: begin ma = signed'(x60);            mb = M60;             end
      OP_P_MUL: begin ma = OPW'(na);                mb = OPW'(pen);       end
      OP_R_MUL: begin ma = signed'(x100);           mb = M100;            end
      OP_C_MUL: begin ma = OPW'(na);                mb = reach;           end
      OP_N_MUL: begin ma = OPW'(va);                mb = OPW'(na);        end
      OP_E_MUL: begin ma = -OPW'(vn);               mb = signed'(OPW'(rest)); end
      OP_D_MUL: begin ma = OPW'(na);                mb = OPW'(delta);     end
      default:  begin ma = '0;                      mb = '0;              end
    endcase
  end

  // product scaled back by one unit, truncated toward zero
  assign fm = (prod + ((prod < 0) ? wide_t'(ONE_M1) : wide_t'(0))) >>> FRAC_BITS;

  // reciprocal quotient with a single correction step
  assign qe   = prod[DIV_SHIFT+29:DIV_SHIFT];
  assign r60  = x60 - OPW'(qe) * OPW'(60);
  assign r100 = x100 - OPW'(qe) * OPW'(100);
  assign q60  = (r60 >= OPW'(60)) ? qe + 30'd1 : qe;
  assign q100 = (r100 >= OPW'(100)) ? qe + 30'd1 : qe;
  assign step = (va < 0) ? -wide_t'(q60) : wide_t'(q60);

  // rebound after restitution, dropped below the threshold
  always_comb begin
    nvn = sat32(fm);
    if (wide_t'(nvn) < wide_t'(REST_MIN)) nvn = '0;
  end

  assign st.kinematic = kinem;
  assign st.vn_neg    = acc[WW-1];
  assign st.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      freeze  <= '0;
      grav_en <= 1'b1;
      kinem   <= 1'b0;
      rest    <= '0;
      radius  <= '0;
      off[0]  <= '0;
      off[1]  <= '0;
      off[2]  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FREEZE:  freeze  <= cfg_data[2:0];
        CFG_GRAVITY: grav_en <= cfg_data[0];
        CFG_KINEM:   kinem   <= cfg_data[0];
        CFG_REST:    rest    <= cfg_data[17:0];
        CFG_RADIUS:  radius  <= cfg_data[30:0];
        CFG_OFF_X:   off[0]  <= cfg_data;
        CFG_OFF_Y:   off[1]  <= cfg_data;
        CFG_OFF_Z:   off[2]  <= cfg_data;
        default:     freeze  <= freeze;
      endcase
    end
  end

  // body state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_GRAV: begin
          if (grav_en && !freeze[1]) vel[1] <= sat32(wide_t'(vel[1]) - wide_t'(GRAV));
        end
        OP_T_USE: begin
          if (freeze[cmd.axis]) vel[cmd.axis] <= '0;
          else pos[cmd.axis] <= sat32(wide_t'(pa) + step);
        end
        OP_P_USE: begin
          if (pen > 0) pos[cmd.axis] <= sat32(wide_t'(pa) + fm);
        end
        OP_C_USE: begin
          pos[cmd.axis] <= sat32(wide_t'(sat32(wide_t'(cpt[cmd.axis]) + fm))
                                 - wide_t'(off[cmd.axis]));
        end
        OP_D_USE: vel[cmd.axis] <= sat32(wide_t'(va) + fm);
        OP_LDPOS: for (int i = 0; i < AXES; i++) pos[i] <= vec[i];
        OP_LDVEL: for (int i = 0; i < AXES; i++) vel[i] <= vec[i];
        default:  pos[0] <= pos[0];
      endcase
    end
  end

  // item latch and intermediate values
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        for (int i = 0; i < AXES; i++) begin
          vec[i] <= in_data[3+32*i +: 32];
          cpt[i] <= in_data[131+32*i +: 32];
        end
        pen <= in_data[130:99];
      end
      OP_R_USE: reach <= OPW'(radius) + OPW'(q100);
      OP_N_USE: acc   <= ((cmd.axis == 2'd0) ? wide_t'(0) : acc) + fm;
      OP_E_USE: delta <= sat32(wide_t'(nvn) - wide_t'(vn));
      default:  acc   <= acc;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_FIN) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIN) begin
      for (int i = 0; i < AXES; i++) begin
        out_pos[i] <= pos[i];
        out_vel[i] <= vel[i];
      end
    end
  end

  assign out_data = {out_vel[2], out_vel[1], out_vel[0], out_pos[2], out_pos[1], out_pos[0]};

endmodule
`default_nettype wire

>>> hw/rtl/rbsc_chk.sv
// port level checks of the rigid body step and contact core, bound to the top
`default_nettype none
module rbsc_chk (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [191:0] m_tdata
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one request at a time: ready drops after an accept
  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind rigid_body_step_and_contact_core rbsc_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

>>> verif/tb_top.sv
// self-checking testbench of the rigid body step and contact core
`timescale 1ns / 1ps
`default_nettype none

// state tracker and result checker for the one simulated body
class body_tracker;
  localparam longint ONE      = 64'sd1 << 16;
  localparam longint GRAV     = ((64'sd98 <<< 16) + 300) / 600;
  localparam longint REB_MIN  = (ONE * 2 + 5) / 10;

  bit [2:0]  freeze;
  bit        grav_on;
  bit        kinem;
  bit [17:0] rest;
  bit [30:0] radius;
  int        coff[3];
  int        pos[3];
  int        vel[3];
  bit [191:0] pending[$];
  int        errors;

  function new();
    freeze = 0; grav_on = 1; kinem = 0; rest = 0; radius = 0;
    for (int i = 0; i < 3; i++) begin
      coff[i] = 0; pos[i] = 0; vel[i] = 0;
    end
    errors = 0;
  endfunction

  function automatic int sat(longint v);
    int r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = int'(v);
    return r;
  endfunction

  function automatic longint fmul(longint a, longint b);
    longint p;
    p = a * b;
    return p / ONE;
  endfunction

  function automatic longint step60(longint v);
    longint r;
    if (v >= 0) r = (v + 30) / 60;
    else r = -((-v + 30) / 60);
    return r;
  endfunction

  function void set_reg(rbsc_pkg::cfg_idx_t idx, bit [31:0] d);
    case (idx)
      rbsc_pkg::CFG_FREEZE:  freeze = d[2:0];
      rbsc_pkg::CFG_GRAVITY: grav_on = d[0];
      rbsc_pkg::CFG_KINEM:   kinem = d[0];
      rbsc_pkg::CFG_REST:    rest = d[17:0];
      rbsc_pkg::CFG_RADIUS:  radius = d[30:0];
      rbsc_pkg::CFG_OFF_X:   coff[0] = d;
      rbsc_pkg::CFG_OFF_Y:   coff[1] = d;
      rbsc_pkg::CFG_OFF_Z:   coff[2] = d;
      default: ;
    endcase
  endfunction

  // reflect the approaching normal velocity
  function void bounce(int n[3]);
    longint vn, nvn, dv;
    vn = 0;
    for (int i = 0; i < 3; i++) vn += fmul(vel[i], n[i]);
    vn = sat(vn);
    if (vn >= 0) return;
    nvn = sat(fmul(-vn, longint'(rest)));
    if (nvn < REB_MIN) nvn = 0;
    dv = sat(nvn - vn);
    for (int i = 0; i < 3; i++) vel[i] = sat(longint'(vel[i]) + fmul(n[i], dv));
  endfunction

  // note an accepted request and queue the body state it leads to
  function void note_request(bit [231:0] d);
    bit [2:0] mode;
    int n[3], c[3], pen;
    longint reach, ctr;
    mode = d[2:0];
    for (int i = 0; i < 3; i++) begin
      n[i] = d[3 + 32*i +: 32];
      c[i] = d[131 + 32*i +: 32];
    end
    pen = d[99 +: 32];
    if (mode == rbsc_pkg::MODE_TICK && !kinem) begin
      if (grav_on && !freeze[1]) vel[1] = sat(longint'(vel[1]) - GRAV);
      for (int i = 0; i < 3; i++)
        if (freeze[i]) vel[i] = 0;
        else pos[i] = sat(longint'(pos[i]) + step60(vel[i]));
    end else if (mode == rbsc_pkg::MODE_CONTACT && !kinem) begin
      if (pen > 0)
        for (int i = 0; i < 3; i++) pos[i] = sat(longint'(pos[i]) + fmul(n[i], pen));
      bounce(n);
    end else if (mode == rbsc_pkg::MODE_CCD && !kinem) begin
      reach = longint'(radius) + (longint'(radius) + 50) / 100;
      for (int i = 0; i < 3; i++) begin
        ctr = sat(longint'(c[i]) + fmul(n[i], reach));
        pos[i] = sat(ctr - coff[i]);
      end
      bounce(n);
    end else if (mode == rbsc_pkg::MODE_LDPOS) begin
      for (int i = 0; i < 3; i++) pos[i] = n[i];
    end else if (mode == rbsc_pkg::MODE_LDVEL) begin
      for (int i = 0; i < 3; i++) vel[i] = n[i];
    end
    pending.push_back({vel[2], vel[1], vel[0], pos[2], pos[1], pos[0]});
  endfunction

  // compare one result with the oldest queued state
  function void check_result(bit [191:0] got);
    bit [191:0] exp;
    string names[6];
    names = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};
    if (pending.size() == 0) begin
      $error("result %h with no request outstanding", got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    for (int i = 0; i < 6; i++)
      if (exp[32*i +: 32] !== got[32*i +: 32]) begin
        $error("%s expected %0d got %0d", names[i], $signed(exp[32*i +: 32]),
               $signed(got[32*i +: 32]));
        errors++;
      end
  endfunction
endclass

module tb_top;
  import rbsc_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [231:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [191:0] m_tdata;
  logic         cfg_we = 0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  body_tracker body = new();
  bit          hold_off = 0;
  bit          sink_on = 0;

  rigid_body_step_and_contact_core dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    #4000000;
    $display("tb_top: errors");
    $finish;
  end

  // check every accepted result
  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) body.check_result(m_tdata);

  function automatic int gap_len();
    int g;
    if ($urandom_range(9) < 6) g = 0;
    else if ($urandom_range(9) < 8) g = $urandom_range(3, 1);
    else g = $urandom_range(40, 10);
    return g;
  endfunction

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int g;
    wait (sink_on);
    forever begin
      if (hold_off) begin
        m_tready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      g = $urandom_range(3) == 0 ? gap_len() : 0;
      if (g > 0) begin
        m_tready <= 0;
        repeat (g) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
    end
  end

  task automatic send(bit [2:0] mode, int n[3], int pen, int c[3]);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {c[2], c[1], c[0], pen, n[2], n[1], n[0], mode};
    do @(posedge clk); while (!s_tready);
    body.note_request({c[2], c[1], c[0], pen, n[2], n[1], n[0], mode});
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (body.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, bit [31:0] d);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    body.set_reg(idx, d);
    @(posedge clk);
  endtask

  function automatic int rnd_val();
    int r;
    case ($urandom_range(5))
      0: r = $urandom;
      1: r = $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
      2: r = $signed($urandom_range(131072)) - 65536;
      default: r = $signed($urandom_range(2000000)) - 1000000;
    endcase
    return r;
  endfunction

  task automatic random_request();
    int n[3], c[3], pen, k;
    bit [2:0] mode;
    k = $urandom_range(99);
    if (k < 40) mode = MODE_TICK;
    else if (k < 60) mode = MODE_CONTACT;
    else if (k < 75) mode = MODE_CCD;
    else if (k < 85) mode = MODE_LDPOS;
    else if (k < 95) mode = MODE_LDVEL;
    else mode = $urandom_range(7, 5);
    for (int i = 0; i < 3; i++) begin
      n[i] = rnd_val();
      c[i] = rnd_val();
    end
    // mostly unit-ish axis normals so contacts produce real bounces
    if (mode inside {MODE_CONTACT, MODE_CCD} && $urandom_range(2) != 0) begin
      n = '{0, 0, 0};
      n[$urandom_range(2)] = $urandom_range(1) ? 65536 : -65536;
    end
    pen = rnd_val();
    send(mode, n, pen, c);
  endtask

  task automatic random_config();
    write_reg(CFG_FREEZE, $urandom_range(7));
    write_reg(CFG_GRAVITY, $urandom);
    write_reg(CFG_KINEM, $urandom_range(5) == 0);
    write_reg(CFG_REST, $urandom_range(3) == 0 ? 32'h3ffff : $urandom_range(131072));
    write_reg(CFG_RADIUS, $urandom_range(3) == 0 ? 32'h7fffffff : $urandom_range(200000));
    write_reg(CFG_OFF_X, rnd_val());
    write_reg(CFG_OFF_Y, rnd_val());
    write_reg(CFG_OFF_Z, rnd_val());
  endtask

  initial begin
    int z[3], mx[3], mn[3], a[3];
    z = '{0, 0, 0};
    mx = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    mn = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
    repeat (12) @(posedge clk);
    rst <= 0;
    sink_on = 1;
    @(posedge clk);

    // directed: every mode, extremes, kinematic loads, unused modes
    send(MODE_TICK, z, 0, z);
    send(MODE_LDVEL, '{65536, -131072, 30}, 0, z);
    send(MODE_TICK, mx, 32'sh7fffffff, mx);
    send(MODE_CONTACT, '{0, 65536, 0}, 65536, mx);
    send(MODE_LDVEL, mn, 0, z);
    send(MODE_TICK, z, 0, z);
    send(MODE_LDPOS, mx, 0, z);
    send(MODE_TICK, z, 0, z);
    send(MODE_LDVEL, mx, 0, z);
    send(MODE_CONTACT, mn, 32'sh7fffffff, z);
    send(MODE_CONTACT, '{3 * 65536, 0, -65536}, -5, z);
    send(MODE_CCD, '{65536, 0, 0}, 0, mn);
    send(5, mx, 1, mx);
    send(7, z, 0, z);
    drain();
    write_reg(CFG_KINEM, 1);
    write_reg(CFG_REST, 32'h3ffff);
    write_reg(CFG_RADIUS, 32'h7fffffff);
    write_reg(CFG_OFF_X, 32'h80000000);
    write_reg(CFG_OFF_Y, 32'h7fffffff);
    write_reg(CFG_OFF_Z, 32'h12345678);
    write_reg(CFG_FREEZE, 7);
    write_reg(CFG_GRAVITY, 0);
    send(MODE_TICK, z, 0, z);
    send(MODE_LDPOS, mn, 0, z);
    send(MODE_LDVEL, '{0, -655360, 0}, 0, z);
    drain();
    write_reg(CFG_KINEM, 0);
    a = '{0, 65536, 0};
    send(MODE_CCD, a, 0, mx);
    send(MODE_CONTACT, a, 100, z);
    send(MODE_TICK, z, 0, z);
    drain();

    // long receiver hold-off while requests keep coming
    hold_off = 1;
    for (int i = 0; i < 8; i++) random_request();

    // random phases with random settings
    for (int ph = 0; ph < 30; ph++) begin
      drain();
      if (ph == 0) begin
        write_reg(CFG_FREEZE, 0);
        write_reg(CFG_GRAVITY, 1);
        write_reg(CFG_REST, 0);
        write_reg(CFG_RADIUS, 0);
      end else random_config();
      for (int i = 0; i < 60; i++) random_request();
    end
    drain();

    if (body.errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end
endmodule

`default_nettype wire
